// ===== rtl/dsc_pkg.sv =====
// ----------------------------------------------------------------------------
// Downscaler package
// Shared widths, the configuration register map and the queue entry type.
// ----------------------------------------------------------------------------
package dsc_pkg;

    localparam int PIX_W      = 32;  // pixel width
    localparam int ACC_W      = 29;  // accumulator and step width
    localparam int POS_W      = 13;  // source and output position counters
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 32;
    localparam int DIMREG_W   = 13;  // width of the dimension registers
    localparam int Q_DEPTH    = 4;
    localparam int Q_AW       = $clog2(Q_DEPTH);
    localparam int Q_CW       = $clog2(Q_DEPTH + 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SRC_WIDTH   = 3'd0,
        CFG_DEST_WIDTH  = 3'd1,
        CFG_DEST_HEIGHT = 3'd2,
        CFG_X_STEP      = 3'd3,
        CFG_Y_STEP      = 3'd4,
        CFG_COLOR_MASK  = 3'd5,
        CFG_PACK_24     = 3'd6
    } t_cfg_idx;

    // One source pixel with its position in the frame.
    typedef struct packed {
        logic             start;
        logic [POS_W-1:0] row;
        logic [POS_W-1:0] col;
        logic [PIX_W-1:0] pixel;
    } t_entry;

endpackage

// ===== rtl/dsc_front.sv =====
// ----------------------------------------------------------------------------
// Downscaler front end
// Accepts source beats, tracks the source column and row, and tags each
// pixel with its position before it enters the queue.
// ----------------------------------------------------------------------------
module dsc_front
    import dsc_pkg::*;
#(
    parameter int DIM_W = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_valid,
    output logic             o_ready,
    input  logic [PIX_W-1:0] i_pixel,
    input  logic             i_start,
    input  logic [DIM_W-1:0] i_src_width,
    input  logic             i_q_full,
    output logic             o_push,
    output t_entry           o_entry
);

    localparam int CMP_W = POS_W + 1;

    logic [POS_W-1:0] r_col, n_col;
    logic [POS_W-1:0] r_row, n_row;
    logic [POS_W-1:0] cur_col, cur_row;
    logic             col_wrap;

    assign o_ready = !i_q_full;
    assign o_push  = i_valid && !i_q_full;

    always_comb begin
        // A frame start puts this pixel at column 0 of row 0.
        cur_col  = i_start ? '0 : r_col;
        cur_row  = i_start ? '0 : r_row;
        col_wrap = (CMP_W'(cur_col) + CMP_W'(1)) >= CMP_W'(i_src_width);
        n_col    = col_wrap ? '0 : cur_col + POS_W'(1);
        n_row    = col_wrap ? cur_row + POS_W'(1) : cur_row;
        o_entry.start = i_start;
        o_entry.row   = cur_row;
        o_entry.col   = cur_col;
        o_entry.pixel = i_pixel;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (o_push) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

endmodule

// ===== rtl/dsc_queue.sv =====
// ----------------------------------------------------------------------------
// Downscaler queue
// Short first-in first-out buffer between the front end and the selector.
// ----------------------------------------------------------------------------
module dsc_queue
    import dsc_pkg::*;
(
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_push,
    input  t_entry i_entry,
    output logic   o_full,
    output logic   o_valid,
    input  logic   i_pop,
    output t_entry o_entry
);

    t_entry            r_mem [Q_DEPTH];
    logic [Q_AW-1:0]   r_wr_ptr;
    logic [Q_AW-1:0]   r_rd_ptr;
    logic [Q_CW-1:0]   r_count;
    logic              do_pop;

    assign o_full  = (r_count == Q_CW'(Q_DEPTH));
    assign o_valid = (r_count != '0);
    assign o_entry = r_mem[r_rd_ptr];
    assign do_pop  = i_pop && o_valid;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr_ptr] <= i_entry;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + Q_AW'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + Q_AW'(1);
            end
            if (i_push && !do_pop) begin
                r_count <= r_count + Q_CW'(1);
            end else if (do_pop && !i_push) begin
                r_count <= r_count - Q_CW'(1);
            end
        end
    end

endmodule

// ===== rtl/dsc_back.sv =====
// ----------------------------------------------------------------------------
// Downscaler selector
// Holds the column and row accumulators, decides for each queued pixel
// whether it is sampled, and drives the registered output beat.
// ----------------------------------------------------------------------------
module dsc_back
    import dsc_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int DIM_W     = 13
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_q_valid,
    input  t_entry           i_entry,
    output logic             o_pop,
    input  logic [DIM_W-1:0] i_dest_width,
    input  logic [DIM_W-1:0] i_dest_height,
    input  logic [ACC_W-1:0] i_x_step,
    input  logic [ACC_W-1:0] i_y_step,
    input  logic [PIX_W-1:0] i_mask,
    output logic             o_valid,
    input  logic             i_ready,
    output logic [PIX_W-1:0] o_pixel,
    output logic             o_row_end,
    output logic             o_frame_end
);

    localparam int CMP_W = POS_W + 1;

    logic [ACC_W-1:0] r_cacc, r_racc;
    logic [POS_W-1:0] r_ocol, r_orow;
    logic             r_done;
    logic             r_out_valid;
    logic [PIX_W-1:0] r_out_pixel;
    logic             r_out_row_end;
    logic             r_out_frame_end;

    logic [ACC_W-1:0] cur_cacc, cur_racc, n_cacc, n_racc;
    logic [POS_W-1:0] cur_ocol, cur_orow, n_ocol, n_orow;
    logic             cur_done, n_done;
    logic             hit, rend, fend;
    logic [ACC_W:0]   csum, rsum;
    logic [ACC_W-1:0] csat, rsat;

    assign o_pop       = i_q_valid && (!r_out_valid || i_ready);
    assign o_valid     = r_out_valid;
    assign o_pixel     = r_out_pixel;
    assign o_row_end   = r_out_row_end;
    assign o_frame_end = r_out_frame_end;

    always_comb begin
        cur_cacc = i_entry.start ? '0 : r_cacc;
        cur_racc = i_entry.start ? '0 : r_racc;
        cur_ocol = i_entry.start ? '0 : r_ocol;
        cur_orow = i_entry.start ? '0 : r_orow;
        cur_done = i_entry.start ? 1'b0 : r_done;

        hit = !cur_done
            && (ACC_W'(i_entry.row) == (cur_racc >> FRAC_BITS))
            && (ACC_W'(i_entry.col) == (cur_cacc >> FRAC_BITS));
        rend = (CMP_W'(cur_ocol) + CMP_W'(1)) >= CMP_W'(i_dest_width);
        fend = rend && ((CMP_W'(cur_orow) + CMP_W'(1)) >= CMP_W'(i_dest_height));

        // Accumulators saturate rather than wrap.
        csum = {1'b0, cur_cacc} + {1'b0, i_x_step};
        rsum = {1'b0, cur_racc} + {1'b0, i_y_step};
        csat = csum[ACC_W] ? '1 : csum[ACC_W-1:0];
        rsat = rsum[ACC_W] ? '1 : rsum[ACC_W-1:0];

        n_cacc = cur_cacc;
        n_racc = cur_racc;
        n_ocol = cur_ocol;
        n_orow = cur_orow;
        n_done = cur_done;
        if (hit) begin
            if (rend) begin
                n_ocol = '0;
                n_cacc = '0;
                n_orow = cur_orow + POS_W'(1);
                n_racc = rsat;
                n_done = fend;
            end else begin
                n_ocol = cur_ocol + POS_W'(1);
                n_cacc = csat;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cacc      <= '0;
            r_racc      <= '0;
            r_ocol      <= '0;
            r_orow      <= '0;
            r_done      <= 1'b1;
            r_out_valid <= 1'b0;
        end else begin
            if (o_pop) begin
                r_cacc      <= n_cacc;
                r_racc      <= n_racc;
                r_ocol      <= n_ocol;
                r_orow      <= n_orow;
                r_done      <= n_done;
                r_out_valid <= hit;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_pop && hit) begin
            r_out_pixel     <= i_entry.pixel & i_mask;
            r_out_row_end   <= rend;
            r_out_frame_end <= fend;
        end
    end

endmodule

// ===== rtl/nearest_neighbor_downscaler.sv =====
// ----------------------------------------------------------------------------
// Nearest-neighbour downscaler
// Picks source pixels on a fixed-point grid to shrink a raster stream.
//
// Input beats carry one 32-bit source pixel in raster order; tuser marks the
// first pixel of a frame. Output beats carry each sampled pixel after the
// colour mask (and top-byte clearing in packed mode), with tlast on the last
// pixel of an output row and tuser on the last pixel of the frame.
// Configuration registers are written through the plain write port; the user
// must write them only while no beat is in flight, as the block itself does
// not enforce this. Values out of range are clamped as they are used.
// One input beat is taken per cycle while the queue is not full. A sampled
// pixel passes through the four-entry queue and then the output register
// behind the selector. When the receiver stalls, the output beat holds, the
// queue fills and s_axis_tready drops once four beats are waiting.
// Synchronous reset empties the queue and the output register, restores the
// register defaults and suppresses all output until the next frame start.
// ----------------------------------------------------------------------------
module nearest_neighbor_downscaler
    import dsc_pkg::*;
#(
    parameter int FRAC_BITS = 16,
    parameter int MAX_DIM   = 4096
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    input  logic [PIX_W-1:0]      s_axis_tdata,   // [31:0] pixel
    input  logic                  s_axis_tuser,   // [0] frame_start
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    output logic [PIX_W-1:0]      m_axis_tdata,   // [31:0] out_pixel
    output logic                  m_axis_tlast,   // row_end
    output logic                  m_axis_tuser,   // [0] frame_end
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);

    localparam int DIM_W = $clog2(MAX_DIM + 1);
    localparam int EXT_W = DIMREG_W + 1;
    localparam logic [ACC_W-1:0] STEP_ONE = ACC_W'(1) << FRAC_BITS;

    logic [DIMREG_W-1:0] r_src_width, r_dest_width, r_dest_height;
    logic [ACC_W-1:0]    r_x_step, r_y_step;
    logic [PIX_W-1:0]    r_color_mask;
    logic                r_pack_24;

    logic [DIM_W-1:0] sw_eff, dw_eff, dh_eff;
    logic [ACC_W-1:0] xs_eff, ys_eff;
    logic [PIX_W-1:0] mask_eff;

    logic   push, q_full, q_valid, pop;
    t_entry f_entry, q_entry;

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIMREG_W-1:0] v);
        logic [EXT_W-1:0] ev;
        logic [EXT_W-1:0] r;
        ev = EXT_W'(v);
        if (ev == '0) begin
            r = EXT_W'(1);
        end else if (ev > EXT_W'(MAX_DIM)) begin
            r = EXT_W'(MAX_DIM);
        end else begin
            r = ev;
        end
        return DIM_W'(r);
    endfunction

    always_comb begin
        sw_eff   = clamp_dim(r_src_width);
        dw_eff   = clamp_dim(r_dest_width);
        dh_eff   = clamp_dim(r_dest_height);
        xs_eff   = (r_x_step < STEP_ONE) ? STEP_ONE : r_x_step;
        ys_eff   = (r_y_step < STEP_ONE) ? STEP_ONE : r_y_step;
        mask_eff = r_color_mask & {{8{~r_pack_24}}, 24'hFF_FFFF};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_src_width   <= DIMREG_W'(640);
            r_dest_width  <= DIMREG_W'(640);
            r_dest_height <= DIMREG_W'(480);
            r_x_step      <= ACC_W'(65536);
            r_y_step      <= ACC_W'(65536);
            r_color_mask  <= '1;
            r_pack_24     <= 1'b0;
        end else if (i_cfg_we) begin
            case (t_cfg_idx'(i_cfg_index))
                CFG_SRC_WIDTH:   r_src_width   <= i_cfg_data[DIMREG_W-1:0];
                CFG_DEST_WIDTH:  r_dest_width  <= i_cfg_data[DIMREG_W-1:0];
                CFG_DEST_HEIGHT: r_dest_height <= i_cfg_data[DIMREG_W-1:0];
                CFG_X_STEP:      r_x_step      <= i_cfg_data[ACC_W-1:0];
                CFG_Y_STEP:      r_y_step      <= i_cfg_data[ACC_W-1:0];
                CFG_COLOR_MASK:  r_color_mask  <= i_cfg_data[PIX_W-1:0];
                CFG_PACK_24:     r_pack_24     <= i_cfg_data[0];
                default: begin
                end
            endcase
        end
    end

    dsc_front #(
        .DIM_W(DIM_W)
    ) u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_pixel     (s_axis_tdata),
        .i_start     (s_axis_tuser),
        .i_src_width (sw_eff),
        .i_q_full    (q_full),
        .o_push      (push),
        .o_entry     (f_entry)
    );

    dsc_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_entry (f_entry),
        .o_full  (q_full),
        .o_valid (q_valid),
        .i_pop   (pop),
        .o_entry (q_entry)
    );

    dsc_back #(
        .FRAC_BITS(FRAC_BITS),
        .DIM_W    (DIM_W)
    ) u_back (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_q_valid     (q_valid),
        .i_entry       (q_entry),
        .o_pop         (pop),
        .i_dest_width  (dw_eff),
        .i_dest_height (dh_eff),
        .i_x_step      (xs_eff),
        .i_y_step      (ys_eff),
        .i_mask        (mask_eff),
        .o_valid       (m_axis_tvalid),
        .i_ready       (m_axis_tready),
        .o_pixel       (m_axis_tdata),
        .o_row_end     (m_axis_tlast),
        .o_frame_end   (m_axis_tuser)
    );

endmodule

// ===== rtl/dsc_checker.sv =====
// ----------------------------------------------------------------------------
// Downscaler port checker
// Checks reset behaviour, output hold under stall and end-marker ordering.
// ----------------------------------------------------------------------------
module dsc_checker
    import dsc_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             s_axis_tready,
    input logic             m_axis_tvalid,
    input logic             m_axis_tready,
    input logic [PIX_W-1:0] m_axis_tdata,
    input logic             m_axis_tlast,
    input logic             m_axis_tuser
);

    // Reset empties the output register.
    a_rst_out: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("output beat valid after reset");

    // Reset empties the queue, so the input side is ready straight after.
    a_rst_ready: assert property (@(posedge i_clk)
        !i_rst_n |=> s_axis_tready)
        else $error("input not ready after reset");

    // A stalled output beat holds its payload.
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tlast) && $stable(m_axis_tuser))
        else $error("stalled output beat changed");

    // The last pixel of a frame always closes an output row.
    a_frame_row: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tlast)
        else $error("frame end without row end");

endmodule

bind nearest_neighbor_downscaler dsc_checker u_dsc_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);
